/* rtl/bba_pkg.sv */
// Shared constants, types and result codes for the buddy block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS        = 64;
  localparam int MAX_ORDER         = 30;
  localparam int TOTAL_ORDER_RESET = 10;

  localparam int ORDER_W = 5;
  localparam int OWNER_W = 31;
  localparam int SIZE_W  = 31;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = $clog2(MAX_BLOCKS);

  localparam int TOTAL_ORDER_INIT =
    (TOTAL_ORDER_RESET > MAX_ORDER) ? MAX_ORDER : TOTAL_ORDER_RESET;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_QUERY = 2'd3
  } status_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [OWNER_W-1:0] owner;
  } ent_t;

  typedef struct packed {
    status_t            status;
    logic [CNT_W-1:0]   block_total;
    logic [OWNER_W-1:0] entry_owner;
    logic [ORDER_W-1:0] entry_order;
    logic               last;
  } res_t;

endpackage

/* rtl/bba_if.sv */
// Request and result channel interfaces of the buddy block allocator.
interface bba_in_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [OWNER_W-1:0] owner_id;
  logic [SIZE_W-1:0]  request_size;

  modport source(output valid, mode, owner_id, request_size, input ready);
  modport sink(input valid, mode, owner_id, request_size, output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [CNT_W-1:0]   block_total;
  logic [OWNER_W-1:0] entry_owner;
  logic [ORDER_W-1:0] entry_order;
  logic               last;

  modport source(output valid, status, block_total, entry_owner, entry_order, last,
                 input ready);
  modport sink(input valid, status, block_total, entry_owner, entry_order, last,
               output ready);
endinterface

/* rtl/bba_need.sv */
// Iterative ceil(log2) unit: one shift and compare per cycle.
module bba_need (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bba_pkg::SIZE_W-1:0] size,
  output logic                       done,
  output logic [bba_pkg::ORDER_W-1:0] need
);
  import bba_pkg::*;

  logic [SIZE_W:0]    pw;
  logic [SIZE_W-1:0]  sz;
  logic [ORDER_W-1:0] idx;
  logic               run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sz  <= size;
        pw  <= (SIZE_W+1)'(1);
        idx <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (pw < {1'b0, sz}) begin
          pw  <= pw << 1;
          idx <= idx + ORDER_W'(1);
        end else begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign need = idx;

endmodule

/* rtl/bba_seq.sv */
// Block list memory and sequencer: scan, shift, split fill and query readout.
module bba_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rebuild,
  input  logic [bba_pkg::ORDER_W-1:0] total_order,
  bba_in_if.sink                      in_ch,
  output logic                        need_start,
  input  logic                        need_done,
  input  logic [bba_pkg::ORDER_W-1:0] need_val,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bba_pkg::res_t               res
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_NEED, ST_SCAN, ST_SHIFT,
    ST_FILL, ST_EXACT, ST_RES, ST_QRD, ST_QOUT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [OWNER_W-1:0] owner;
  logic [ORDER_W-1:0] need;
  logic [CNT_W-1:0]   j;
  logic               chk_v;
  logic [ADDR_W-1:0]  chk_idx;
  logic               lfound;
  logic [ADDR_W-1:0]  lpos;
  logic [ORDER_W-1:0] lorder;
  logic [ORDER_W-1:0] s;
  logic [ADDR_W-1:0]  sk;
  logic               wv;
  logic [ADDR_W-1:0]  widx;
  logic [ORDER_W-1:0] fi;
  status_t            rstat;
  logic [ADDR_W-1:0]  qidx;

  ent_t               mem [MAX_BLOCKS];
  ent_t               mem_q;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  ent_t               mem_wdata;

  logic               in_fire;
  logic               hit_exact;
  logic               hit_larger;
  logic [ORDER_W-1:0] split_n;
  logic [SUM_W-1:0]   grown;
  logic               qlast;

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
  end

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign need_start = in_fire && !in_ch.mode;
  assign hit_exact  = chk_v && (mem_q.owner == '0) && (mem_q.order == need);
  assign hit_larger = chk_v && (mem_q.owner == '0) && (mem_q.order > need);
  assign split_n    = lorder - need;
  assign grown      = {1'b0, cnt} + SUM_W'(split_n);
  assign qlast      = ({1'b0, qidx} + CNT_W'(1)) == cnt;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = j[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state)
      ST_INIT: begin
        mem_we          = 1'b1;
        mem_wdata.order = total_order;
      end
      ST_SCAN: begin
        mem_re = (j < cnt);
      end
      ST_SHIFT: begin
        mem_re    = (sk > lpos);
        mem_raddr = sk;
        mem_we    = wv;
        mem_waddr = widx + ADDR_W'(s);
        mem_wdata = mem_q;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = lpos + ADDR_W'(fi);
        if (fi == '0) begin
          mem_wdata.order = need;
          mem_wdata.owner = owner;
        end else begin
          mem_wdata.order = need + fi - ORDER_W'(1);
        end
      end
      ST_EXACT: begin
        mem_we          = 1'b1;
        mem_waddr       = lpos;
        mem_wdata.order = need;
        mem_wdata.owner = owner;
      end
      ST_QRD: begin
        mem_re    = 1'b1;
        mem_raddr = qidx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= CNT_W'(1);
      chk_v <= 1'b0;
      wv    <= 1'b0;
    end else if (rebuild) begin
      state <= ST_INIT;
    end else begin
      case (state)
        ST_INIT: begin
          cnt   <= CNT_W'(1);
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            owner <= in_ch.owner_id;
            qidx  <= '0;
            state <= in_ch.mode ? ST_QRD : ST_NEED;
          end
        end
        ST_NEED: begin
          if (need_done) begin
            need   <= need_val;
            j      <= '0;
            chk_v  <= 1'b0;
            lfound <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_exact) begin
            lpos  <= chk_idx;
            chk_v <= 1'b0;
            state <= ST_EXACT;
          end else begin
            if (hit_larger && !lfound) begin
              lfound <= 1'b1;
              lpos   <= chk_idx;
              lorder <= mem_q.order;
            end
            if (j < cnt) begin
              chk_v   <= 1'b1;
              chk_idx <= j[ADDR_W-1:0];
              j       <= j + CNT_W'(1);
            end else begin
              chk_v <= 1'b0;
              if (!chk_v) begin
                if (!lfound) begin
                  rstat <= STAT_NOFIT;
                  state <= ST_RES;
                end else if (grown > SUM_W'(MAX_BLOCKS)) begin
                  rstat <= STAT_FULL;
                  state <= ST_RES;
                end else begin
                  s     <= split_n;
                  sk    <= ADDR_W'(cnt - CNT_W'(1));
                  wv    <= 1'b0;
                  state <= ST_SHIFT;
                end
              end
            end
          end
        end
        ST_SHIFT: begin
          if (sk > lpos) begin
            wv   <= 1'b1;
            widx <= sk;
            sk   <= sk - ADDR_W'(1);
          end else begin
            wv <= 1'b0;
            if (!wv) begin
              fi    <= s;
              state <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (fi == '0) begin
            cnt   <= cnt + CNT_W'(s);
            rstat <= STAT_ALLOC;
            state <= ST_RES;
          end else begin
            fi <= fi - ORDER_W'(1);
          end
        end
        ST_EXACT: begin
          rstat <= STAT_ALLOC;
          state <= ST_RES;
        end
        ST_RES: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_QRD: begin
          state <= ST_QOUT;
        end
        ST_QOUT: begin
          if (res_ready) begin
            if (qlast) begin
              state <= ST_IDLE;
            end else begin
              qidx  <= qidx + ADDR_W'(1);
              state <= ST_QRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_valid       = (state == ST_RES) || (state == ST_QOUT);
    res.block_total = cnt;
    if (state == ST_QOUT) begin
      res.status      = STAT_QUERY;
      res.entry_owner = mem_q.owner;
      res.entry_order = mem_q.order;
      res.last        = qlast;
    end else begin
      res.status      = rstat;
      res.entry_owner = (rstat == STAT_ALLOC) ? owner : '0;
      res.entry_order = (rstat == STAT_ALLOC) ? need : '0;
      res.last        = 1'b1;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CNT_W'(1)) && (cnt <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_fill_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (({1'b0, cnt} + SUM_W'(s)) <= SUM_W'(MAX_BLOCKS)))
    else $error("split overflows block list");

  a_exact_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXACT) |-> ({1'b0, lpos} < cnt))
    else $error("exact grant outside list");

  a_shift_right: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && wv) |-> (widx > lpos))
    else $error("shift touches split block");
`endif

endmodule

/* rtl/buddy_block_allocator.sv */
// Buddy block allocator top level: config register, result register, unit wiring.
// Allocate: ceil(log2) of the size, then a list scan for an exact free fit, else the
//   first larger free block; a split shifts later blocks and fills, then the result.
// Query: one memory read per block, one result per block in the list.
// One item at a time; the block memory, one read and one write a cycle, sets the pace.
// Reset: one free block of order 10 in entry 0; a config write rebuilds the list.
module buddy_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORDER_W-1:0] cfg_data,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch
);
  import bba_pkg::*;

  logic [ORDER_W-1:0] total_order;
  logic               need_start;
  logic               need_done;
  logic [ORDER_W-1:0] need_val;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ov;
  res_t               oreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_order <= ORDER_W'(TOTAL_ORDER_INIT);
    end else if (cfg_we) begin
      total_order <= (cfg_data > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : cfg_data;
    end
  end

  bba_need u_need (
    .clk   (clk),
    .rst   (rst),
    .start (need_start),
    .size  (in_ch.request_size),
    .done  (need_done),
    .need  (need_val)
  );

  bba_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .rebuild     (cfg_we),
    .total_order (total_order),
    .in_ch       (in_ch),
    .need_start  (need_start),
    .need_done   (need_done),
    .need_val    (need_val),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !ov || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (res_valid && res_ready) begin
      ov   <= 1'b1;
      oreg <= res;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.status      = oreg.status;
  assign out_ch.block_total = oreg.block_total;
  assign out_ch.entry_owner = oreg.entry_owner;
  assign out_ch.entry_order = oreg.entry_order;
  assign out_ch.last        = oreg.last;

endmodule

/* tb/sv/buddy_block_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the buddy block allocator: request/result traffic against a list tracker.
module buddy_block_allocator_test;
  import bba_pkg::*;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;
  localparam int   LIMIT_CYCLES = 1000000;
  localparam int   TAIL_CYCLES  = 200;
  localparam int   REPORT_MAX   = 10;

  class block_list_tracker;
    logic [ORDER_W-1:0] blk_order[MAX_BLOCKS];
    logic [OWNER_W-1:0] blk_owner[MAX_BLOCKS];
    int                 blk_count;
    int                 total_order;
    res_t               pending_reports[$];
    int                 mismatches;

    function new();
      total_order = TOTAL_ORDER_INIT;
      mismatches  = 0;
      rebuild();
    endfunction

    function void rebuild();
      foreach (blk_order[i]) begin
        blk_order[i] = '0;
        blk_owner[i] = '0;
      end
      blk_order[0] = ORDER_W'(total_order);
      blk_count    = 1;
    endfunction

    function void set_total_order(logic [ORDER_W-1:0] value);
      total_order = (value > MAX_ORDER) ? MAX_ORDER : int'(value);
      rebuild();
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void push_report(status_t st, logic [OWNER_W-1:0] own,
                              logic [ORDER_W-1:0] ord, logic lst);
      res_t r;
      r.status      = st;
      r.block_total = CNT_W'(blk_count);
      r.entry_owner = own;
      r.entry_order = ord;
      r.last        = lst;
      pending_reports.push_back(r);
    endfunction

    function void apply_request(logic m, logic [OWNER_W-1:0] own, logic [SIZE_W-1:0] sz);
      int need;
      int pos;
      int splits;
      int j;
      need = 0;
      pos  = -1;
      if (m == MODE_QUERY) begin
        for (j = 0; j < blk_count; j++)
          push_report(STAT_QUERY, blk_owner[j], blk_order[j], j == blk_count - 1);
        return;
      end
      while (need < 40 && (64'd1 << need) < {33'd0, sz}) need++;
      for (j = 0; j < blk_count; j++) begin
        if (blk_owner[j] == '0 && blk_order[j] == need) begin
          blk_owner[j] = own;
          push_report(STAT_ALLOC, own, ORDER_W'(need), 1'b1);
          return;
        end
      end
      for (j = 0; j < blk_count && pos < 0; j++)
        if (blk_owner[j] == '0 && blk_order[j] > need) pos = j;
      if (pos < 0) begin
        push_report(STAT_NOFIT, '0, '0, 1'b1);
        return;
      end
      splits = int'(blk_order[pos]) - need;
      if (blk_count + splits > MAX_BLOCKS) begin
        push_report(STAT_FULL, '0, '0, 1'b1);
        return;
      end
      // halve left-first: right halves land above pos in ascending order
      for (j = blk_count - 1; j > pos; j--) begin
        blk_order[j + splits] = blk_order[j];
        blk_owner[j + splits] = blk_owner[j];
      end
      for (j = 1; j <= splits; j++) begin
        blk_order[pos + j] = ORDER_W'(need + j - 1);
        blk_owner[pos + j] = '0;
      end
      blk_order[pos] = ORDER_W'(need);
      blk_owner[pos] = own;
      blk_count += splits;
      push_report(STAT_ALLOC, own, ORDER_W'(need), 1'b1);
    endfunction

    function void match_report(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("bba_tb: unexpected transfer status %0d total %0d owner %h order %0d last %0b",
                   got.status, got.block_total, got.entry_owner, got.entry_order, got.last);
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status || got.block_total !== want.block_total ||
          got.entry_owner !== want.entry_owner || got.entry_order !== want.entry_order ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"bba_tb: mismatch exp/act status %0d/%0d total %0d/%0d ",
                    "owner %h/%h order %0d/%0d last %0b/%0b"},
                   want.status, got.status, want.block_total, got.block_total,
                   want.entry_owner, got.entry_owner, want.entry_order, got.entry_order,
                   want.last, got.last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [ORDER_W-1:0] cfg_data;
  bit                 calm = 1'b0;
  int                 hold_off_cycles = 0;

  block_list_tracker tracker = new();

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  buddy_block_allocator i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #1 clk = ~clk;

  function automatic logic [SIZE_W-1:0] size_for_order(int n);
    if (n == 0) return SIZE_W'($urandom_range(0, 1));
    if (n > MAX_ORDER) return SIZE_W'($urandom_range(32'h7FFF_FFFF, 32'h4000_0001));
    return SIZE_W'($urandom_range(32'd1 << n, (32'd1 << (n - 1)) + 1));
  endfunction

  task automatic send_item(input logic m, input logic [OWNER_W-1:0] own,
                           input logic [SIZE_W-1:0] sz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.owner_id     <= own;
    in_ch.request_size <= sz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.apply_request(m, own, sz);
  endtask

  task automatic send_random_item(input int tot);
    logic               m;
    int                 need;
    logic [OWNER_W-1:0] own;
    m = ($urandom_range(0, 7) == 0) ? MODE_QUERY : MODE_ALLOC;
    case ($urandom_range(0, 3))
      0, 1: need = $urandom_range(0, 2);
      2: need = $urandom_range(0, tot);
      default: need = $urandom_range(0, 31);
    endcase
    own = ($urandom_range(0, 15) == 0) ? '0 : OWNER_W'($urandom());
    send_item(m, own, size_for_order(need));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_total_order(input logic [ORDER_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_total_order(value);
  endtask

  initial begin : result_sink
    int   stall_left;
    res_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.status      = status_t'(out_ch.status);
        got.block_total = out_ch.block_total;
        got.entry_owner = out_ch.entry_owner;
        got.entry_order = out_ch.entry_order;
        got.last        = out_ch.last;
        tracker.match_report(got);
      end
      if (hold_off_cycles > 0) begin
        stall_left      = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

  initial begin : stimulus
    int phase_order[6];
    int p;
    phase_order = '{12, 7, 31, 0, 20, 30};
    phase_order[3] = $urandom_range(0, 31);
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_ALLOC;
    in_ch.owner_id     <= '0;
    in_ch.request_size <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_QUERY, 31'h0, 31'h0);
    send_item(MODE_ALLOC, 31'h7FFF_FFFF, 31'd0);
    send_item(MODE_ALLOC, 31'h1, 31'd1);
    send_item(MODE_ALLOC, 31'h0, 31'd2);
    send_item(MODE_ALLOC, 31'h2AAA_AAAA, 31'd3);
    send_item(MODE_ALLOC, 31'h5555_5555, 31'd1024);
    send_item(MODE_ALLOC, 31'h100, 31'h7FFF_FFFF);
    send_item(MODE_ALLOC, 31'h33, 31'd512);
    send_item(MODE_QUERY, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    wait_drained();

    write_total_order(5'd0);
    send_item(MODE_ALLOC, 31'h2, 31'd2);
    send_item(MODE_ALLOC, 31'h7FFF_FFFE, 31'd1);
    send_item(MODE_ALLOC, 31'h3, 31'd0);
    send_item(MODE_QUERY, 31'h0, 31'h0);
    wait_drained();

    write_total_order(5'd31);
    send_item(MODE_ALLOC, 31'h1234_5678, 31'h4000_0000);
    send_item(MODE_ALLOC, 31'h9, 31'd0);
    send_item(MODE_QUERY, 31'h0, 31'h0);
    wait_drained();

    // single-unit requests fragment the list until it refuses further splits
    write_total_order(5'd30);
    repeat (40)
      send_item(MODE_ALLOC, ($urandom_range(0, 15) == 0) ? '0 : OWNER_W'($urandom()),
                size_for_order(0));
    send_item(MODE_QUERY, OWNER_W'($urandom()), SIZE_W'($urandom()));

    hold_off_cycles = 400;
    repeat (8) send_random_item(tracker.total_order);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      if (p == 5) calm = 1'b1;
      write_total_order(ORDER_W'(phase_order[p]));
      repeat (28) send_random_item(tracker.total_order);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("[buddy_block_allocator] OK");
    else
      $display("[buddy_block_allocator] ERROR");
    $finish;
  end

endmodule

/* buddy_block_allocator.f */
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_need.sv
rtl/bba_seq.sv
rtl/buddy_block_allocator.sv
tb/sv/buddy_block_allocator_test.sv
